// File: hdl/set_associative_cache_4way_top_defines.svh
// Assertion macros for the cache block.
`ifndef SET_ASSOCIATIVE_CACHE_4WAY_TOP_DEFINES_SVH
`define SET_ASSOCIATIVE_CACHE_4WAY_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SAC4W_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");
`define SAC4W_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");
`else
`define SAC4W_ASSERT_IMPL(label, ante, cons)
`define SAC4W_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/sac4w_pkg.sv
package sac4w_pkg;

    localparam int ADDR_W = 16;
    localparam int TAG_W  = 9;
    localparam int AGE_W  = 8;
    localparam int OUT_W  = 64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LREAD,
        ST_LCAP,
        ST_WB,
        ST_FILL,
        ST_UPDATE
    } sac4w_state_t;

endpackage

// File: hdl/sac4w_ram.sv
module sac4w_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/set_associative_cache_4way_top.sv
// Set-associative write-back cache in front of a byte-wide backing memory.
// A request is taken at a rising edge where start is high and busy is low;
// address, opcode (0 read, 1 write) and write_byte are sampled then.
// The block then runs one request at a time and holds busy high.
// A read gives one result: line_bytes, was_hit and was_dirty are valid for
// exactly one cycle while result_strobe is high, in the first cycle after
// busy falls. A write gives no result. The receiver cannot stall; results
// are simply presented for one cycle.
// Busy covers the way scan, the line read and capture and the update on a
// hit, and write-back and fill besides on a miss. A new request can be taken
// in the cycle busy falls. The tag and age lookup walks the ways one per cycle
// through the read ports of the tag and age memories, and write-back and fill
// move one byte per cycle through the byte-wide backing memory.
// After reset the backing memory is cleared one byte per cycle with busy high.
// Cache entries start as tag 0, clean, zero data and age equal to the way.
`include "set_associative_cache_4way_top_defines.svh"

module set_associative_cache_4way_top #(
    parameter int NUM_SETS   = 16,
    parameter int NUM_WAYS   = 4,
    parameter int LINE_BYTES = 8,
    parameter int MEM_BYTES  = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sac4w_pkg::ADDR_W-1:0] address,
    input  logic                        opcode,
    input  logic [7:0]                  write_byte,
    output logic                        result_strobe,
    output logic [sac4w_pkg::OUT_W-1:0] line_bytes,
    output logic                        was_hit,
    output logic                        was_dirty
);

    import sac4w_pkg::*;

    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int OFF_W       = $clog2(LINE_BYTES);
    localparam int IDX_W       = SET_W + WAY_W;
    localparam int CNT_W       = $clog2(LINE_BYTES + 1);
    localparam int WCNT_W      = $clog2(NUM_WAYS + 1);
    localparam int LINE_W      = LINE_BYTES * 8;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int BASE_W      = TAG_W + SET_W + OFF_W;
    localparam int TAGD_W      = TAG_W + 1;
    localparam int CACHE_DEPTH = NUM_SETS * NUM_WAYS;

    sac4w_state_t state_reg, state_next;

    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic                   op_reg, op_next;
    logic [7:0]             wbyte_reg, wbyte_next;
    logic [WCNT_W-1:0]      way_cnt_reg, way_cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [WAY_W-1:0]       cmp_way_reg, cmp_way_next;
    logic                   hit_reg, hit_next;
    logic [WAY_W-1:0]       sel_way_reg, sel_way_next;
    logic [AGE_W-1:0]       sel_age_reg, sel_age_next;
    logic [TAG_W-1:0]       sel_tag_reg, sel_tag_next;
    logic                   sel_dirty_reg, sel_dirty_next;
    logic [LINE_W-1:0]      line_reg, line_next;
    logic [CNT_W-1:0]       byte_cnt_reg, byte_cnt_next;
    logic [MEM_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CACHE_DEPTH-1:0] entry_valid_reg, entry_valid_next;
    logic [CACHE_DEPTH-1:0] age_valid_reg, age_valid_next;
    logic [OUT_W-1:0]       line_out_reg, line_out_next;
    logic                   hit_out_reg, hit_out_next;
    logic                   dirty_out_reg, dirty_out_next;
    logic                   strobe_reg, strobe_next;

    logic [ADDR_W-1:0]        addr_shift;
    logic [TAG_W-1:0]         cur_tag;
    logic [SET_W-1:0]         cur_set;
    logic [OFF_W-1:0]         cur_off;
    logic [IDX_W-1:0]         scan_idx;
    logic [IDX_W-1:0]         cmp_idx;
    logic [IDX_W-1:0]         sel_idx;
    logic [TAGD_W-1:0]        tagd_q;
    logic [AGE_W-1:0]         age_q;
    logic [LINE_W-1:0]        line_q;
    logic [7:0]               mem_q;
    logic [TAG_W-1:0]         cmp_tag;
    logic                     cmp_dirty;
    logic [AGE_W-1:0]         cmp_age;
    logic [MEM_AW+BASE_W-1:0] old_base_full;
    logic [MEM_AW+BASE_W-1:0] new_base_full;
    logic [MEM_AW-1:0]        old_base;
    logic [MEM_AW-1:0]        new_base;
    logic [OFF_W-1:0]         byte_off;
    logic [CNT_W-1:0]         cnt_dec;
    logic [OFF_W-1:0]         fill_idx;
    logic [LINE_W-1:0]        line_mod;
    logic                     dirty_new;
    logic [LINE_W+OUT_W-1:0]  line_ext;
    logic                     accept;

    logic                     tag_we;
    logic [TAGD_W-1:0]        tag_wdata;
    logic                     age_we;
    logic [IDX_W-1:0]         age_waddr;
    logic [AGE_W-1:0]         age_wdata;
    logic                     line_we;
    logic                     mem_we;
    logic [MEM_AW-1:0]        mem_waddr;
    logic [7:0]               mem_wdata;
    logic [MEM_AW-1:0]        mem_raddr;

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign result_strobe = strobe_reg;
    assign line_bytes    = line_out_reg;
    assign was_hit       = hit_out_reg;
    assign was_dirty     = dirty_out_reg;

    assign addr_shift    = addr_reg >> (OFF_W + SET_W);
    assign cur_tag       = addr_shift[TAG_W-1:0];
    assign cur_set       = addr_reg[OFF_W +: SET_W];
    assign cur_off       = addr_reg[OFF_W-1:0];
    assign scan_idx      = {cur_set, way_cnt_reg[WAY_W-1:0]};
    assign cmp_idx       = {cur_set, cmp_way_reg};
    assign sel_idx       = {cur_set, sel_way_reg};

    assign cmp_tag       = entry_valid_reg[cmp_idx] ? tagd_q[TAGD_W-1:1] : '0;
    assign cmp_dirty     = entry_valid_reg[cmp_idx] ? tagd_q[0] : 1'b0;
    assign cmp_age       = age_valid_reg[cmp_idx] ? age_q : AGE_W'(cmp_way_reg);

    assign old_base_full = {{MEM_AW{1'b0}}, sel_tag_reg, cur_set, {OFF_W{1'b0}}};
    assign new_base_full = {{MEM_AW{1'b0}}, cur_tag, cur_set, {OFF_W{1'b0}}};
    assign old_base      = old_base_full[MEM_AW-1:0];
    assign new_base      = new_base_full[MEM_AW-1:0];
    assign byte_off      = byte_cnt_reg[OFF_W-1:0];
    assign cnt_dec       = byte_cnt_reg - CNT_W'(1);
    assign fill_idx      = cnt_dec[OFF_W-1:0];
    assign dirty_new     = op_reg || (hit_reg && sel_dirty_reg);
    assign line_ext      = {{OUT_W{1'b0}}, line_mod};

    always_comb
    begin
        line_mod = line_reg;
        if (op_reg)
        begin
            line_mod[cur_off*8 +: 8] = wbyte_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == MEM_AW'(MEM_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (way_cnt_reg == WCNT_W'(NUM_WAYS))
                begin
                    state_next = ST_LREAD;
                end
            end
            ST_LREAD:
            begin
                state_next = ST_LCAP;
            end
            ST_LCAP:
            begin
                state_next = hit_reg ? ST_UPDATE : ST_WB;
            end
            ST_WB:
            begin
                if (byte_cnt_reg == CNT_W'(LINE_BYTES - 1))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (byte_cnt_reg == CNT_W'(LINE_BYTES))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tag_we    = (state_reg == ST_UPDATE);
        line_we   = (state_reg == ST_UPDATE);
        tag_wdata = {cur_tag, dirty_new};
        age_we    = (state_reg == ST_UPDATE) || (state_reg == ST_SCAN && cmp_vld_reg);
        age_waddr = (state_reg == ST_UPDATE) ? sel_idx : cmp_idx;
        age_wdata = (state_reg == ST_UPDATE) ? '0 : cmp_age + AGE_W'(1);
        mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WB);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg
                                            : old_base + MEM_AW'(byte_cnt_reg);
        mem_wdata = (state_reg == ST_CLEAR) ? 8'h00 : line_reg[byte_off*8 +: 8];
        mem_raddr = new_base + MEM_AW'(byte_cnt_reg);
    end

    always_comb
    begin
        addr_next        = addr_reg;
        op_next          = op_reg;
        wbyte_next       = wbyte_reg;
        way_cnt_next     = way_cnt_reg;
        cmp_vld_next     = (state_reg == ST_SCAN) && (way_cnt_reg < WCNT_W'(NUM_WAYS));
        cmp_way_next     = way_cnt_reg[WAY_W-1:0];
        hit_next         = hit_reg;
        sel_way_next     = sel_way_reg;
        sel_age_next     = sel_age_reg;
        sel_tag_next     = sel_tag_reg;
        sel_dirty_next   = sel_dirty_reg;
        line_next        = line_reg;
        byte_cnt_next    = byte_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        entry_valid_next = entry_valid_reg;
        age_valid_next   = age_valid_reg;
        line_out_next    = line_out_reg;
        hit_out_next     = hit_out_reg;
        dirty_out_next   = dirty_out_reg;
        strobe_next      = (state_reg == ST_UPDATE) && !op_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next    = address;
                    op_next      = opcode;
                    wbyte_next   = write_byte;
                    way_cnt_next = '0;
                    hit_next     = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (way_cnt_reg < WCNT_W'(NUM_WAYS))
                begin
                    way_cnt_next = way_cnt_reg + WCNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    age_valid_next[cmp_idx] = 1'b1;
                    if (!hit_reg)
                    begin
                        if (cmp_tag == cur_tag)
                        begin
                            hit_next       = 1'b1;
                            sel_way_next   = cmp_way_reg;
                            sel_tag_next   = cmp_tag;
                            sel_dirty_next = cmp_dirty;
                        end
                        else if (cmp_way_reg == '0 || cmp_age > sel_age_reg)
                        begin
                            sel_way_next   = cmp_way_reg;
                            sel_age_next   = cmp_age;
                            sel_tag_next   = cmp_tag;
                            sel_dirty_next = cmp_dirty;
                        end
                    end
                end
            end
            ST_LREAD:
            begin
                byte_cnt_next = '0;
            end
            ST_LCAP:
            begin
                line_next     = entry_valid_reg[sel_idx] ? line_q : '0;
                byte_cnt_next = '0;
            end
            ST_WB:
            begin
                if (byte_cnt_reg == CNT_W'(LINE_BYTES - 1))
                begin
                    byte_cnt_next = '0;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                end
            end
            ST_FILL:
            begin
                byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                if (byte_cnt_reg != '0)
                begin
                    line_next[fill_idx*8 +: 8] = mem_q;
                end
            end
            ST_UPDATE:
            begin
                entry_valid_next[sel_idx] = 1'b1;
                age_valid_next[sel_idx]   = 1'b1;
                line_out_next             = line_ext[OUT_W-1:0];
                hit_out_next              = hit_reg;
                dirty_out_next            = sel_dirty_reg;
            end
            default:
            begin
                clr_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            way_cnt_reg     <= '0;
            cmp_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            byte_cnt_reg    <= '0;
            entry_valid_reg <= '0;
            age_valid_reg   <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            way_cnt_reg     <= way_cnt_next;
            cmp_vld_reg     <= cmp_vld_next;
            hit_reg         <= hit_next;
            byte_cnt_reg    <= byte_cnt_next;
            entry_valid_reg <= entry_valid_next;
            age_valid_reg   <= age_valid_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        op_reg        <= op_next;
        wbyte_reg     <= wbyte_next;
        cmp_way_reg   <= cmp_way_next;
        sel_way_reg   <= sel_way_next;
        sel_age_reg   <= sel_age_next;
        sel_tag_reg   <= sel_tag_next;
        sel_dirty_reg <= sel_dirty_next;
        line_reg      <= line_next;
        line_out_reg  <= line_out_next;
        hit_out_reg   <= hit_out_next;
        dirty_out_reg <= dirty_out_next;
    end

    sac4w_ram #(
        .WIDTH (TAGD_W),
        .DEPTH (CACHE_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (sel_idx),
        .wdata (tag_wdata),
        .raddr (scan_idx),
        .rdata (tagd_q)
    );

    sac4w_ram #(
        .WIDTH (AGE_W),
        .DEPTH (CACHE_DEPTH)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (scan_idx),
        .rdata (age_q)
    );

    sac4w_ram #(
        .WIDTH (LINE_W),
        .DEPTH (CACHE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (sel_idx),
        .wdata (line_mod),
        .raddr (sel_idx),
        .rdata (line_q)
    );

    sac4w_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_backing_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    `SAC4W_ASSERT_NEXT(a_read_gives_result, state_reg == ST_UPDATE && !op_reg, strobe_reg)
    `SAC4W_ASSERT_IMPL(a_refill_only_on_miss, state_reg == ST_WB || state_reg == ST_FILL, !hit_reg)
    `SAC4W_ASSERT_IMPL(a_result_while_idle, strobe_reg, state_reg == ST_IDLE)

endmodule

// File: tb/set_associative_cache_4way_top_tb.sv
module set_associative_cache_4way_top_tb;

    import sac4w_pkg::*;

    localparam int NUM_SETS    = 16;
    localparam int NUM_WAYS    = 4;
    localparam int LINE_BYTES  = 8;
    localparam int MEM_BYTES   = 65536;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PAUSE_AT_A  = 19;
    localparam int PAUSE_AT_B  = 420;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              opcode;
        logic [7:0]        write_byte;
    } cache_request_t;

    typedef struct packed {
        logic [OUT_W-1:0] line_bytes;
        logic             was_hit;
        logic             was_dirty;
    } read_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [ADDR_W-1:0] address = '0;
    logic              opcode = OP_READ;
    logic [7:0]        write_byte = '0;
    logic              result_strobe;
    logic [OUT_W-1:0]  line_bytes;
    logic              was_hit;
    logic              was_dirty;

    set_associative_cache_4way_top #(
        .NUM_SETS  (NUM_SETS),
        .NUM_WAYS  (NUM_WAYS),
        .LINE_BYTES(LINE_BYTES),
        .MEM_BYTES (MEM_BYTES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .address      (address),
        .opcode       (opcode),
        .write_byte   (write_byte),
        .result_strobe(result_strobe),
        .line_bytes   (line_bytes),
        .was_hit      (was_hit),
        .was_dirty    (was_dirty)
    );

    always #4 clk = ~clk;

    logic [TAG_W-1:0] tag_copy [NUM_SETS][NUM_WAYS];
    logic [7:0]       line_copy [NUM_SETS][NUM_WAYS][LINE_BYTES];
    logic             dirty_copy [NUM_SETS][NUM_WAYS];
    logic [AGE_W-1:0] age_copy [NUM_SETS][NUM_WAYS];
    logic [7:0]       memory_copy [MEM_BYTES];

    cache_request_t pending_requests [$];
    read_result_t   expected_reads [$];

    int mismatch_count = 0;
    int sent_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit fire_now;
    bit raise_now;
    cache_request_t next_request;
    read_result_t   seen_read;
    read_result_t   want_read;

    task automatic cache_model_access(input logic [ADDR_W-1:0] a, input logic op,
                                      input logic [7:0] wb);
        int set_i;
        int way_i;
        int sel;
        int i;
        logic [TAG_W-1:0] tag;
        logic [2:0] offs;
        bit hit;
        bit dirty_before;
        logic [ADDR_W-1:0] old_base;
        logic [ADDR_W-1:0] new_base;
        read_result_t r;
        offs = a[2:0];
        set_i = a[6:3];
        tag = a[15:7];
        sel = 0;
        hit = 1'b0;
        for (way_i = 0; way_i < NUM_WAYS; way_i++)
        begin
            if (!hit)
            begin
                if (tag_copy[set_i][way_i] == tag)
                begin
                    sel = way_i;
                    hit = 1'b1;
                end
                else if (way_i == 0 || age_copy[set_i][way_i] > age_copy[set_i][sel])
                begin
                    sel = way_i;
                end
            end
        end
        dirty_before = dirty_copy[set_i][sel];
        if (!hit)
        begin
            old_base = {tag_copy[set_i][sel], 4'(set_i), 3'b000};
            new_base = {tag, 4'(set_i), 3'b000};
            for (i = 0; i < LINE_BYTES; i++)
                memory_copy[ADDR_W'(old_base + i)] = line_copy[set_i][sel][i];
            for (i = 0; i < LINE_BYTES; i++)
                line_copy[set_i][sel][i] = memory_copy[ADDR_W'(new_base + i)];
            tag_copy[set_i][sel] = tag;
            dirty_copy[set_i][sel] = 1'b0;
        end
        if (op == OP_WRITE)
        begin
            line_copy[set_i][sel][offs] = wb;
            dirty_copy[set_i][sel] = 1'b1;
        end
        for (way_i = 0; way_i < NUM_WAYS; way_i++)
            age_copy[set_i][way_i] = age_copy[set_i][way_i] + 1'b1;
        age_copy[set_i][sel] = '0;
        if (op == OP_READ)
        begin
            for (i = 0; i < 8; i++)
                r.line_bytes[8*i +: 8] = line_copy[set_i][sel][i];
            r.was_hit = hit;
            r.was_dirty = dirty_before;
            expected_reads.push_back(r);
        end
    endtask

    task automatic push_request(input logic [ADDR_W-1:0] a, input logic op,
                                input logic [7:0] wb);
        cache_request_t q;
        q.address = a;
        q.opcode = op;
        q.write_byte = wb;
        pending_requests.push_back(q);
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        logic [TAG_W-1:0] tag;
        if ($urandom_range(0, 99) < 15)
            return ADDR_W'($urandom);
        tag = ($urandom_range(0, 19) == 0) ? 9'h1FF : TAG_W'($urandom_range(0, 5));
        return {tag, 4'($urandom_range(0, NUM_SETS - 1)), 3'($urandom_range(0, 7))};
    endfunction

    initial
    begin
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                tag_copy[s][w] = '0;
                dirty_copy[s][w] = 1'b0;
                age_copy[s][w] = AGE_W'(w);
                for (int b = 0; b < LINE_BYTES; b++)
                    line_copy[s][w][b] = '0;
            end
        for (int m = 0; m < MEM_BYTES; m++)
            memory_copy[m] = '0;
    end

    initial
    begin
        logic [TAG_W-1:0] ham_tag [3];
        logic [3:0] ham_set;
        int pick;

        push_request(16'h0000, OP_READ, 8'h00);
        push_request(16'h0038, OP_READ, 8'h00);
        push_request(16'h0007, OP_WRITE, 8'hA5);
        push_request(16'h0000, OP_READ, 8'h00);
        push_request(16'hFFFF, OP_READ, 8'h00);
        push_request(16'hFFFF, OP_WRITE, 8'hFF);
        push_request(16'hFFF8, OP_READ, 8'h00);
        push_request(16'h0080, OP_READ, 8'h00);
        push_request(16'h0100, OP_WRITE, 8'h00);
        push_request(16'h0180, OP_READ, 8'h00);
        push_request(16'h0200, OP_READ, 8'h00);
        push_request(16'h0000, OP_READ, 8'h00);
        push_request(16'h5555, OP_WRITE, 8'h3C);
        push_request(16'h5555, OP_READ, 8'h00);
        push_request(16'hAAAA, OP_WRITE, 8'hC3);
        push_request(16'h2AAA, OP_READ, 8'h00);
        push_request(16'hAAAA, OP_READ, 8'h00);
        push_request(16'h0100, OP_READ, 8'h00);
        push_request(16'hFFFF, OP_READ, 8'h00);
        push_request(16'h7FFF, OP_READ, 8'h00);

        for (int n = 0; n < 240; n++)
            push_request(random_address(), logic'($urandom_range(0, 1)), 8'($urandom));

        ham_set = 4'($urandom_range(0, NUM_SETS - 1));
        ham_tag[0] = TAG_W'($urandom_range(0, 127));
        ham_tag[1] = ham_tag[0] + 9'd128;
        ham_tag[2] = ham_tag[0] + 9'd256;
        for (int n = 0; n < 3; n++)
            push_request({ham_tag[n], ham_set, 3'b000}, OP_READ, 8'h00);
        for (int n = 0; n < 262; n++)
        begin
            pick = $urandom_range(0, 2);
            push_request({ham_tag[pick], ham_set, 3'($urandom_range(0, 7))},
                         logic'($urandom_range(0, 1)), 8'($urandom));
        end
        push_request({ham_tag[0] + 9'd1, ham_set, 3'b000}, OP_READ, 8'h00);
        push_request({ham_tag[0] + 9'd2, ham_set, 3'b000}, OP_READ, 8'h00);

        for (int n = 0; n < 240; n++)
            push_request(random_address(), logic'($urandom_range(0, 1)), 8'($urandom));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_requests.size() != 0 || start)
            @(posedge clk);
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_reads.size() == 0)
            $display("set_associative_cache_4way_top_tb: clean");
        else
            $display("set_associative_cache_4way_top_tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            fire_now = start && !busy;
            raise_now = 1'b0;
            if (fire_now)
            begin
                cache_model_access(address, opcode, write_byte);
                sent_count++;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
                    burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
                end
            end
            if (!start || fire_now)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if ((sent_count == PAUSE_AT_A || sent_count == PAUSE_AT_B) &&
                         (fire_now || busy || result_strobe || expected_reads.size() != 0))
                begin
                    raise_now = 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_request = pending_requests.pop_front();
                    address <= next_request.address;
                    opcode <= next_request.opcode;
                    write_byte <= next_request.write_byte;
                    raise_now = 1'b1;
                end
            end
            else
            begin
                raise_now = 1'b1;
            end
            start <= raise_now;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            seen_read.line_bytes = line_bytes;
            seen_read.was_hit = was_hit;
            seen_read.was_dirty = was_dirty;
            if (expected_reads.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected read result: line %h hit %b dirty %b",
                             line_bytes, was_hit, was_dirty);
            end
            else
            begin
                want_read = expected_reads.pop_front();
                if (seen_read.line_bytes !== want_read.line_bytes ||
                    seen_read.was_hit !== want_read.was_hit ||
                    seen_read.was_dirty !== want_read.was_dirty)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("read mismatch: line exp %h got %h, hit exp %b got %b, dirty exp %b got %b",
                                 want_read.line_bytes, seen_read.line_bytes,
                                 want_read.was_hit, seen_read.was_hit,
                                 want_read.was_dirty, seen_read.was_dirty);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("set_associative_cache_4way_top_tb: errors");
            $finish;
        end
    end

endmodule
